FILE: hdl/pva_pkg.sv
`timescale 1ns / 1ps
package pva_pkg;
  localparam int VOICES = 16;
  localparam int SW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam int KEYS = 128;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_PEDAL   = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STG_PRESS    = 2'd0,
    STG_SUSTAIN  = 2'd1,
    STG_RELEASED = 2'd2
  } stage_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEAL,
    ST_SHIFT,
    ST_FIND,
    ST_WRITE,
    ST_PRESS_OUT,
    ST_TICK_RD,
    ST_TICK_WAIT,
    ST_TICK_EVAL,
    ST_TICK_OUT,
    ST_TICK_END,
    ST_TICK_LAST
  } state_t;

  typedef struct packed {
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [1:0]  stg;
    logic [15:0] rel;
  } voice_t;
endpackage

FILE: hdl/pva_ram.sv
`timescale 1ns / 1ps
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/poly_voice_allocator_top.sv
`timescale 1ns / 1ps
// channel | ports                                                  | handshake
// in      | in_kind in_key in_velocity in_pedal_down               | in_valid/in_ready
// out     | out_voice_id out_voice_key out_voice_velocity out_stage | out_valid/out_ready
//         | out_release_count out_stolen out_last                  |
// cfg     | cfg_release_ticks                                      | cfg_we, no wait
// key release and pedal change only update the key map or pedal flag; a press
// steals and shifts the age list when all voices are busy, then scans for a slot,
// before its result is loaded; a tick reads, updates and writes back each voice in
// turn via the single voice store read port, frees expired ones, then hands over any held final report
// rst_n is synchronous; key map, slot flags, count and register clear at once.
// each result waits in the output register until transferred, stalling the walk;
// a tick holds each report back one voice so the last flag lands on the final survivor
module poly_voice_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [6:0]  in_key,
  input  logic [6:0]  in_velocity,
  input  logic        in_pedal_down,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_voice_id,
  output logic [6:0]  out_voice_key,
  output logic [6:0]  out_voice_velocity,
  output logic [1:0]  out_stage,
  output logic [15:0] out_release_count,
  output logic        out_stolen,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_release_ticks
);
  localparam int SW = pva_pkg::SW;
  localparam int CW = pva_pkg::CW;
  localparam int VW = $bits(pva_pkg::voice_t);

  pva_pkg::state_t state_r, state_nxt;
  logic [pva_pkg::KEYS-1:0] held_r;
  logic pedal_r;
  logic [pva_pkg::VOICES-1:0] used_r, used_nxt;
  logic [SW-1:0] age_r [pva_pkg::VOICES];
  logic [CW-1:0] live_r, live_nxt;
  logic [15:0] rt_r;
  logic [CW-1:0] idx_r, idx_nxt, kept_r, kept_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic stolen_r, stolen_nxt;
  logic [6:0] key_r, vel_r;
  pva_pkg::voice_t cur_r, cur_nxt;
  logic age_we;
  logic [SW-1:0] age_wa, age_wd;

  logic v_we;
  logic [SW-1:0] v_wa, v_ra;
  pva_pkg::voice_t v_wd, v_rd;
  logic [VW-1:0] v_rd_raw;

  logic ov_r, ov_nxt;
  logic [3:0] oid_r, oid_nxt;
  pva_pkg::voice_t ovc_r, ovc_nxt;
  logic ost_r, ost_nxt, olast_r, olast_nxt;

  logic hv_r, hv_nxt;
  logic [3:0] hid_r, hid_nxt;
  pva_pkg::voice_t hvc_r, hvc_nxt;

  pva_ram #(.WIDTH(VW), .DEPTH(pva_pkg::VOICES)) u_voice_ram (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd_raw)
  );
  assign v_rd = pva_pkg::voice_t'(v_rd_raw);

  logic free_hit;
  assign free_hit = (cur_r.stg == pva_pkg::STG_RELEASED) && (cur_r.rel >= rt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pva_pkg::ST_IDLE;
      held_r  <= '0;
      pedal_r <= 1'b0;
      used_r  <= '0;
      live_r  <= '0;
      rt_r    <= '0;
      ov_r    <= 1'b0;
      hv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      live_r  <= live_nxt;
      ov_r    <= ov_nxt;
      hv_r    <= hv_nxt;
      if (cfg_we) begin
        rt_r <= cfg_release_ticks;
      end
      if (in_valid && in_ready) begin
        case (pva_pkg::kind_t'(in_kind))
          pva_pkg::KIND_PRESS:   held_r[in_key] <= 1'b1;
          pva_pkg::KIND_RELEASE: held_r[in_key] <= 1'b0;
          pva_pkg::KIND_PEDAL:   pedal_r <= in_pedal_down;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    kept_r   <= kept_nxt;
    slot_r   <= slot_nxt;
    stolen_r <= stolen_nxt;
    cur_r    <= cur_nxt;
    oid_r    <= oid_nxt;
    ovc_r    <= ovc_nxt;
    ost_r    <= ost_nxt;
    olast_r  <= olast_nxt;
    hid_r    <= hid_nxt;
    hvc_r    <= hvc_nxt;
    if (in_valid && in_ready) begin
      key_r <= in_key;
      vel_r <= in_velocity;
    end
    if (age_we) begin
      age_r[age_wa] <= age_wd;
    end
  end

  assign in_ready = (state_r == pva_pkg::ST_IDLE) && !ov_r;

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    live_nxt   = live_r;
    idx_nxt    = idx_r;
    kept_nxt   = kept_r;
    slot_nxt   = slot_r;
    stolen_nxt = stolen_r;
    cur_nxt    = cur_r;
    ov_nxt     = ov_r && !out_ready;
    oid_nxt    = oid_r;
    ovc_nxt    = ovc_r;
    ost_nxt    = ost_r;
    olast_nxt  = olast_r;
    hv_nxt     = hv_r;
    hid_nxt    = hid_r;
    hvc_nxt    = hvc_r;
    age_we     = 1'b0;
    age_wa     = idx_r[SW-1:0];
    age_wd     = '0;
    v_we       = 1'b0;
    v_wa       = slot_r;
    v_wd       = cur_r;
    v_ra       = age_r[idx_r[SW-1:0]];
    case (state_r)
      pva_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          stolen_nxt = 1'b0;
          idx_nxt    = '0;
          kept_nxt   = '0;
          if (in_kind == pva_pkg::KIND_PRESS) begin
            state_nxt = (live_r >= CW'(pva_pkg::VOICES)) ? pva_pkg::ST_STEAL
                                                         : pva_pkg::ST_FIND;
          end else if (in_kind == pva_pkg::KIND_TICK) begin
            state_nxt = (live_r == '0) ? pva_pkg::ST_IDLE : pva_pkg::ST_TICK_RD;
          end
        end
      end
      pva_pkg::ST_STEAL: begin
        used_nxt[age_r[0]] = 1'b0;
        stolen_nxt = 1'b1;
        live_nxt   = CW'(pva_pkg::VOICES - 1);
        idx_nxt    = CW'(1);
        state_nxt  = (pva_pkg::VOICES > 1) ? pva_pkg::ST_SHIFT : pva_pkg::ST_FIND;
      end
      pva_pkg::ST_SHIFT: begin
        age_we = 1'b1;
        age_wa = SW'(idx_r - CW'(1));
        age_wd = age_r[idx_r[SW-1:0]];
        idx_nxt = idx_r + CW'(1);
        if (idx_r == CW'(pva_pkg::VOICES - 1)) begin
          idx_nxt   = '0;
          state_nxt = pva_pkg::ST_FIND;
        end
      end
      pva_pkg::ST_FIND: begin
        slot_nxt = idx_r[SW-1:0];
        if (!used_r[idx_r[SW-1:0]] || idx_r == CW'(pva_pkg::VOICES - 1)) begin
          state_nxt = pva_pkg::ST_WRITE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      pva_pkg::ST_WRITE: begin
        used_nxt[slot_r] = 1'b1;
        v_we      = 1'b1;
        v_wd.key  = key_r;
        v_wd.vel  = vel_r;
        v_wd.stg  = pva_pkg::STG_PRESS;
        v_wd.rel  = '0;
        cur_nxt   = v_wd;
        age_we    = 1'b1;
        age_wa    = live_r[SW-1:0];
        age_wd    = slot_r;
        live_nxt  = live_r + CW'(1);
        state_nxt = pva_pkg::ST_PRESS_OUT;
      end
      pva_pkg::ST_PRESS_OUT: begin
        if (!ov_r) begin
          ov_nxt    = 1'b1;
          oid_nxt   = 4'(slot_r);
          ovc_nxt   = cur_r;
          ost_nxt   = stolen_r;
          olast_nxt = 1'b1;
          state_nxt = pva_pkg::ST_IDLE;
        end
      end
      pva_pkg::ST_TICK_RD: begin
        slot_nxt  = age_r[idx_r[SW-1:0]];
        state_nxt = pva_pkg::ST_TICK_WAIT;
      end
      pva_pkg::ST_TICK_WAIT: begin
        cur_nxt = v_rd;
        if (v_rd.stg == pva_pkg::STG_RELEASED && v_rd.rel != 16'hFFFF) begin
          cur_nxt.rel = v_rd.rel + 16'd1;
        end
        if ((v_rd.stg == pva_pkg::STG_PRESS || v_rd.stg == pva_pkg::STG_SUSTAIN) &&
            !held_r[v_rd.key]) begin
          cur_nxt.stg = pedal_r ? pva_pkg::STG_SUSTAIN : pva_pkg::STG_RELEASED;
        end
        state_nxt = pva_pkg::ST_TICK_EVAL;
      end
      pva_pkg::ST_TICK_EVAL: begin
        v_we = 1'b1;
        if (free_hit) begin
          used_nxt[slot_r] = 1'b0;
          state_nxt = pva_pkg::ST_TICK_END;
        end else begin
          age_we    = 1'b1;
          age_wa    = kept_r[SW-1:0];
          age_wd    = slot_r;
          kept_nxt  = kept_r + CW'(1);
          state_nxt = pva_pkg::ST_TICK_OUT;
        end
      end
      pva_pkg::ST_TICK_OUT: begin
        if (!hv_r) begin
          hv_nxt    = 1'b1;
          hid_nxt   = 4'(slot_r);
          hvc_nxt   = cur_r;
          state_nxt = pva_pkg::ST_TICK_END;
        end else if (!ov_r) begin
          ov_nxt    = 1'b1;
          oid_nxt   = hid_r;
          ovc_nxt   = hvc_r;
          ost_nxt   = 1'b0;
          olast_nxt = 1'b0;
          hid_nxt   = 4'(slot_r);
          hvc_nxt   = cur_r;
          state_nxt = pva_pkg::ST_TICK_END;
        end
      end
      pva_pkg::ST_TICK_END: begin
        idx_nxt = idx_r + CW'(1);
        if (idx_r + CW'(1) >= live_r) begin
          live_nxt  = kept_r;
          state_nxt = hv_r ? pva_pkg::ST_TICK_LAST : pva_pkg::ST_IDLE;
        end else begin
          state_nxt = pva_pkg::ST_TICK_RD;
        end
      end
      pva_pkg::ST_TICK_LAST: begin
        if (!ov_r) begin
          ov_nxt    = 1'b1;
          oid_nxt   = hid_r;
          ovc_nxt   = hvc_r;
          ost_nxt   = 1'b0;
          olast_nxt = 1'b1;
          hv_nxt    = 1'b0;
          state_nxt = pva_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pva_pkg::ST_IDLE;
    endcase
  end

  assign out_valid          = ov_r;
  assign out_voice_id       = oid_r;
  assign out_voice_key      = ovc_r.key;
  assign out_voice_velocity = ovc_r.vel;
  assign out_stage          = ovc_r.stg;
  assign out_release_count  = ovc_r.rel;
  assign out_stolen         = ost_r;
  assign out_last           = olast_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == pva_pkg::ST_IDLE) else $error("ready outside idle");
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(pva_pkg::VOICES)) else $error("live count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(oid_r)) else $error("result lost");
endmodule
